// ===== rtl/pvg_pkg.sv =====
// shared types and constants of the plot vertex generator
package pvg_pkg;

  localparam int FracBitsDefault = 16;
  localparam int SampleW         = 17;
  localparam int QueueDepth      = 4;
  localparam int CfgIdxW         = 3;
  localparam int CfgDataW        = 16;

  typedef enum logic [1:0] {
    STYLE_SIMPLE = 2'd0,
    STYLE_PRE    = 2'd1,
    STYLE_POST   = 2'd2,
    STYLE_BARS   = 2'd3
  } style_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_STYLE    = 3'd0,
    REG_SHADOW   = 3'd1,
    REG_ORIGIN_X = 3'd2,
    REG_ORIGIN_Y = 3'd3,
    REG_SPAN_W   = 3'd4,
    REG_SPAN_H   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    style_t             style;
    logic               shadow;
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [15:0]        span_w;
    logic [15:0]        span_h;
  } cfg_t;

  typedef struct packed {
    logic [SampleW-1:0] x;
    logic [SampleW-1:0] y;
    logic               has_left;
    logic [SampleW-1:0] lx;
    logic               has_next;
    logic [SampleW-1:0] nx;
    logic [SampleW-1:0] ny;
    logic               run_end;
    logic               series_end;
  } job_t;

endpackage

// ===== rtl/pvg_queue.sv =====
// job queue between the sample front end and the vertex back end
module pvg_queue #(
  parameter int DEPTH = pvg_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pvg_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output pvg_pkg::job_t head_job
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  pvg_pkg::job_t      entries [DEPTH];
  logic [PtrW-1:0]    wr_ptr;
  logic [PtrW-1:0]    rd_ptr;
  logic [CntW-1:0]    count;

  assign full       = (count == CntW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

// ===== rtl/pvg_front.sv =====
// sample front end: neighbour history and job generation
module pvg_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_valid,
  output logic                        sample_stall,
  input  logic [pvg_pkg::SampleW-1:0] sample_x,
  input  logic [pvg_pkg::SampleW-1:0] sample_y,
  input  logic                        last_sample,
  input  logic                        q_full,
  output logic                        q_push,
  output pvg_pkg::job_t               q_job
);

  logic [pvg_pkg::SampleW-1:0] older_x;
  logic [pvg_pkg::SampleW-1:0] prev_x;
  logic [pvg_pkg::SampleW-1:0] prev_y;
  logic                        have_prev;
  logic                        have_older;
  logic                        pend_valid;
  pvg_pkg::job_t               pend_job;
  pvg_pkg::job_t               held_job;
  pvg_pkg::job_t               cur_job;
  logic                        accept;

  assign sample_stall = pend_valid || q_full;
  assign accept       = sample_valid && !sample_stall;

  always_comb begin
    held_job            = '0;
    held_job.x          = prev_x;
    held_job.y          = prev_y;
    held_job.has_left   = have_older;
    held_job.lx         = older_x;
    held_job.has_next   = 1'b1;
    held_job.nx         = sample_x;
    held_job.ny         = sample_y;
    held_job.run_end    = !last_sample;
    held_job.series_end = 1'b0;

    cur_job             = '0;
    cur_job.x           = sample_x;
    cur_job.y           = sample_y;
    cur_job.has_left    = have_prev;
    cur_job.lx          = prev_x;
    cur_job.has_next    = 1'b0;
    cur_job.run_end     = 1'b1;
    cur_job.series_end  = 1'b1;
  end

  always_comb begin
    q_push = 1'b0;
    q_job  = pend_job;
    priority if (pend_valid) begin
      q_push = !q_full;
    end else if (accept && have_prev) begin
      q_push = 1'b1;
      q_job  = held_job;
    end else if (accept && last_sample) begin
      q_push = 1'b1;
      q_job  = cur_job;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && have_prev && last_sample) begin
      pend_job <= cur_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      older_x    <= '0;
      prev_x     <= '0;
      prev_y     <= '0;
      have_prev  <= 1'b0;
      have_older <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (pend_valid && !q_full) begin
        pend_valid <= 1'b0;
      end
      if (accept) begin
        if (last_sample) begin
          older_x    <= '0;
          prev_x     <= '0;
          prev_y     <= '0;
          have_prev  <= 1'b0;
          have_older <= 1'b0;
          pend_valid <= have_prev;
        end else begin
          older_x    <= prev_x;
          have_older <= have_prev;
          prev_x     <= sample_x;
          prev_y     <= sample_y;
          have_prev  <= 1'b1;
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
      accept && have_prev && last_sample |=> pend_valid)
    else $error("flush of held sample lost its second job");
  assert property (@(posedge clk) disable iff (rst)
      pend_valid |-> !have_prev && !have_older)
    else $error("history not cleared at end of series");

endmodule

// ===== rtl/pvg_back.sv =====
// vertex back end: corner sequencer, scale multipliers and saturation
module pvg_back #(
  parameter int FRAC_BITS = pvg_pkg::FracBitsDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  pvg_pkg::cfg_t cfg,
  input  logic          head_valid,
  input  pvg_pkg::job_t head_job,
  output logic          pop,
  output logic          vert_valid,
  input  logic          vert_stall,
  output logic [15:0]   vert_x,
  output logic [15:0]   vert_y,
  output logic          run_last,
  output logic          series_last
);

  localparam int CoordW = (FRAC_BITS + 3 > pvg_pkg::SampleW + 2) ?
                          FRAC_BITS + 3 : pvg_pkg::SampleW + 2;
  localparam int ProdW  = CoordW + 16;
  localparam int Shift  = FRAC_BITS + 2;
  localparam int MapW   = ProdW - Shift;
  localparam int SumW   = MapW + 2;
  localparam logic signed [SumW-1:0] MaxV = {{(SumW-15){1'b0}}, 15'h7fff};
  localparam logic signed [SumW-1:0] MinV = {{(SumW-15){1'b1}}, 15'h0000};

  function automatic logic [15:0] map_sat(input logic [ProdW-1:0] prod,
                                          input logic signed [15:0] org);
    logic [MapW-1:0]        mapped;
    logic signed [SumW-1:0] sum;
    mapped = prod[ProdW-1:Shift];
    sum = $signed({2'b00, mapped}) + $signed({{(SumW-16){org[15]}}, org});
    if (sum > MaxV) begin
      map_sat = 16'h7fff;
    end else if (sum < MinV) begin
      map_sat = 16'h8000;
    end else begin
      map_sat = sum[15:0];
    end
  endfunction

  logic              en;
  logic              issue;
  logic              last_vert;
  logic [2:0]        k;
  logic [2:0]        n;
  logic [CoordW-1:0] x4, y4, nx4, ny4, one4, bx0, bx1;
  logic [CoordW-1:0] vx, vy;
  logic              idx, bottom;

  logic              s1_valid, s1_run, s1_series;
  logic [CoordW-1:0] s1_x, s1_y;
  logic              s2_valid, s2_run, s2_series;
  logic [ProdW-1:0]  s2_px, s2_py;

  assign en        = !(vert_valid && vert_stall);
  assign issue     = head_valid && en;
  assign last_vert = (k == n - 3'd1);
  assign pop       = issue && last_vert;

  assign x4   = CoordW'({head_job.x, 2'b00});
  assign y4   = CoordW'({head_job.y, 2'b00});
  assign nx4  = CoordW'({head_job.nx, 2'b00});
  assign ny4  = CoordW'({head_job.ny, 2'b00});
  assign one4 = CoordW'(1) << (FRAC_BITS + 2);
  assign bx0  = head_job.has_left ?
                CoordW'({head_job.x, 1'b0}) + CoordW'(head_job.x) + CoordW'(head_job.lx) :
                x4;
  assign bx1  = head_job.has_next ?
                CoordW'({head_job.x, 1'b0}) + CoordW'(head_job.x) + CoordW'(head_job.nx) :
                x4;
  assign idx    = cfg.shadow ? k[1] : k[0];
  assign bottom = cfg.shadow && k[0];

  always_comb begin
    unique case (cfg.style)
      pvg_pkg::STYLE_SIMPLE: n = cfg.shadow ? 3'd2 : 3'd1;
      pvg_pkg::STYLE_PRE,
      pvg_pkg::STYLE_POST:   n = cfg.shadow ? (head_job.has_next ? 3'd4 : 3'd2) :
                                              (head_job.has_next ? 3'd2 : 3'd1);
      pvg_pkg::STYLE_BARS:   n = cfg.shadow ? 3'd6 : 3'd4;
      default:               n = 3'd1;
    endcase
  end

  always_comb begin
    vx = x4;
    vy = y4;
    if (cfg.style == pvg_pkg::STYLE_BARS) begin
      unique case (k)
        3'd0: begin
          vx = bx0;
          vy = one4;
        end
        3'd1: begin
          vx = bx0;
          vy = y4;
        end
        3'd2: begin
          vx = bx1;
          vy = y4;
        end
        3'd3: begin
          vx = cfg.shadow ? bx0 : bx1;
          vy = one4;
        end
        3'd4: begin
          vx = bx1;
          vy = one4;
        end
        default: begin
          vx = bx1;
          vy = y4;
        end
      endcase
    end else begin
      vx = (idx && cfg.style == pvg_pkg::STYLE_POST) ? nx4 : x4;
      vy = bottom ? one4 : ((idx && cfg.style == pvg_pkg::STYLE_PRE) ? ny4 : y4);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (issue) begin
      k <= last_vert ? 3'd0 : k + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      vert_valid <= 1'b0;
    end else if (en) begin
      s1_valid   <= issue;
      s2_valid   <= s1_valid;
      vert_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x        <= vx;
      s1_y        <= vy;
      s1_run      <= last_vert && head_job.run_end;
      s1_series   <= last_vert && head_job.run_end && head_job.series_end;
      s2_px       <= ProdW'(s1_x) * ProdW'(cfg.span_w);
      s2_py       <= ProdW'(s1_y) * ProdW'(cfg.span_h);
      s2_run      <= s1_run;
      s2_series   <= s1_series;
      vert_x      <= map_sat(s2_px, cfg.origin_x);
      vert_y      <= map_sat(s2_py, cfg.origin_y);
      run_last    <= s2_run;
      series_last <= s2_series;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
      vert_valid && series_last |-> run_last)
    else $error("series end flagged away from the end of a transaction run");
  assert property (@(posedge clk) disable iff (rst)
      head_valid && !en |=> $stable(k))
    else $error("corner counter moved while the output was held");

endmodule

// ===== rtl/plot_vertex_generator.sv =====
// top level of the plot vertex generator
// Each sample is turned into screen vertices, one vertex per cycle at the output
// while it is not stalled. A sample's vertices leave when the next sample arrives,
// since step and bar styles need that neighbour; the first sample of a series only
// fills the history, and the last one flushes the held sample and itself. A sample
// makes 1 or 2 vertices for simple, 1 to 4 for the step styles, 4 or 6 for bars,
// up to 12 on the flushing sample; the corner sequencer in the back end issues them,
// one vertex a cycle while the output is not stalled. The flushing sample queues
// its second job from a pending register once the queue has room. A four-entry job
// queue sits between the sample side and the vertex side, and a vertex passes the
// s1, s2 and output registers once its job reaches the head of the queue. Registers
// are read as vertices leave and should be written while the block is idle.
module plot_vertex_generator #(
  parameter int FRAC_BITS   = pvg_pkg::FracBitsDefault,
  parameter int QUEUE_DEPTH = pvg_pkg::QueueDepth
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [pvg_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [pvg_pkg::CfgDataW-1:0] cfg_data,
  input  logic                         sample_valid,
  output logic                         sample_stall,
  input  logic [pvg_pkg::SampleW-1:0]  sample_x,
  input  logic [pvg_pkg::SampleW-1:0]  sample_y,
  input  logic                         last_sample,
  output logic                         vert_valid,
  input  logic                         vert_stall,
  output logic [15:0]                  vert_x,
  output logic [15:0]                  vert_y,
  output logic                         run_last,
  output logic                         series_last
);

  pvg_pkg::cfg_t cfg;
  logic          q_full;
  logic          q_push;
  pvg_pkg::job_t q_job;
  logic          q_pop;
  logic          head_valid;
  pvg_pkg::job_t head_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pvg_pkg::REG_STYLE:    cfg.style    <= pvg_pkg::style_t'(cfg_data[1:0]);
        pvg_pkg::REG_SHADOW:   cfg.shadow   <= cfg_data[0];
        pvg_pkg::REG_ORIGIN_X: cfg.origin_x <= $signed(cfg_data);
        pvg_pkg::REG_ORIGIN_Y: cfg.origin_y <= $signed(cfg_data);
        pvg_pkg::REG_SPAN_W:   cfg.span_w   <= cfg_data;
        pvg_pkg::REG_SPAN_H:   cfg.span_h   <= cfg_data;
        default:               cfg          <= cfg;
      endcase
    end
  end

  pvg_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_x     (sample_x),
    .sample_y     (sample_y),
    .last_sample  (last_sample),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (q_job)
  );

  pvg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  pvg_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .head_valid  (head_valid),
    .head_job    (head_job),
    .pop         (q_pop),
    .vert_valid  (vert_valid),
    .vert_stall  (vert_stall),
    .vert_x      (vert_x),
    .vert_y      (vert_y),
    .run_last    (run_last),
    .series_last (series_last)
  );

endmodule
